FILE: src/fbfa_pkg.sv
// ----------------------------------------------------------------------------
// Frame bit field access package
// Shared constants, command and status codes, and the frame store request.
// ----------------------------------------------------------------------------
`default_nettype none

package fbfa_pkg;

	localparam int FRAME_BYTES = 64;
	localparam int ADDR_W      = $clog2(FRAME_BYTES);

	localparam logic [6:0] MAX_FIELD_BITS = 7'd64;
	localparam logic [6:0] FRAME_LEN_RST  = 7'd64;

	localparam logic [1:0] CMD_LOAD    = 2'd0;
	localparam logic [1:0] CMD_READ    = 2'd1;
	localparam logic [1:0] CMD_EXTRACT = 2'd2;
	localparam logic [1:0] CMD_INSERT  = 2'd3;

	localparam logic [1:0] STS_OK       = 2'd0;
	localparam logic [1:0] STS_BAD_LEN  = 2'd1;
	localparam logic [1:0] STS_PAST_END = 2'd2;

	typedef struct packed {
		logic              rd;
		logic [ADDR_W-1:0] rd_addr;
		logic              wr;
		logic [ADDR_W-1:0] wr_addr;
		logic [7:0]        wr_data;
	} store_req_t;

endpackage

`default_nettype wire

FILE: src/frame_bit_field_access.sv
// ----------------------------------------------------------------------------
// Frame bit field access
// Byte load and read, and bit field extract and insert on a 64-byte frame.
// ----------------------------------------------------------------------------
// The slave channel takes one command per transaction: s_tuser carries the
// command and s_tdata the operands. Each command gives exactly one result
// transaction on the master channel with the field, the byte and a status.
// The frame length register is written through cfg_we and cfg_wdata; the user
// must write it only while the block is idle, the block does not enforce it.
// Fields move through the frame store one byte per cycle: a field spanning k
// bytes (1 to 9) is read, or read and rewritten, with byte alignment and byte
// swap steps around it. A load and an error go straight to the result; a byte
// read first waits for its store read. A new command is taken in the cycle after
// the previous result has moved to the output register. A stalled result waits
// in the output register while the next command is processed; that command
// then holds until the output frees.
// Reset clears the frame to zero and sets the frame length to 64 bytes.
// ----------------------------------------------------------------------------
`default_nettype none

module frame_bit_field_access
	import fbfa_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [6:0]  cfg_wdata,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// byte_index, byte_value, bit_offset, bit_length, field_value,
	// msb_first, big_endian
	input  wire logic [95:0] s_tdata,
	// command
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// field_out, byte_out, status, zero fill
	output logic      [79:0] m_tdata
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RDB   = 3'd1;
	localparam logic [2:0] S_RUN   = 3'd2;
	localparam logic [2:0] S_ALIGN = 3'd3;
	localparam logic [2:0] S_SWAP  = 3'd4;
	localparam logic [2:0] S_SHIFT = 3'd5;
	localparam logic [2:0] S_DONE  = 3'd6;

	function automatic logic [63:0] len_mask(input logic [6:0] len);
		logic [63:0] m;
		for (int i = 0; i < 64; i++) begin
			m[i] = 7'(i) < len;
		end
		return m;
	endfunction

	function automatic logic [63:0] swap_bytes(input logic [63:0] v, input logic [3:0] cnt);
		logic [63:0] r;
		r = '0;
		for (int k = 0; k < 8; k++) begin
			for (int j = 0; j < 8; j++) begin
				if (4'(j) + 4'(k) + 4'd1 == cnt) begin
					r[8*k +: 8] = v[8*j +: 8];
				end
			end
		end
		return r;
	endfunction

	logic [1:0]        cmd_in;
	logic [5:0]        byte_index;
	logic [7:0]        byte_value;
	logic [8:0]        bit_offset;
	logic [6:0]        bit_length;
	logic [63:0]       field_value;
	logic              msb_first;
	logic              big_endian;

	assign cmd_in      = s_tuser;
	assign byte_index  = s_tdata[5:0];
	assign byte_value  = s_tdata[13:6];
	assign bit_offset  = s_tdata[22:14];
	assign bit_length  = s_tdata[29:23];
	assign field_value = s_tdata[93:30];
	assign msb_first   = s_tdata[94];
	assign big_endian  = s_tdata[95];

	logic [2:0]        state_q;
	logic [6:0]        frame_len_q;
	logic [3:0]        rd_cnt_q;
	logic              pend_q;
	logic              m_tvalid_q;
	logic [79:0]       m_tdata_q;
	logic [1:0]        cmd_q;
	logic [1:0]        status_q;
	logic [6:0]        len_q;
	logic [2:0]        sh_q;
	logic              swap_q;
	logic              dir_up_q;
	logic [ADDR_W-1:0] addr_q;
	logic [ADDR_W-1:0] prev_addr_q;
	logic [71:0]       work_q;
	logic [71:0]       mm_q;

	store_req_t        req;
	logic [7:0]        rd_data;

	logic              in_acc;
	logic              out_free;
	logic [6:0]        flen;
	logic [9:0]        end_pos;
	logic [9:0]        last_pos;
	logic              bad_len;
	logic              past_end;
	logic [5:0]        first_byte;
	logic [5:0]        last_byte;
	logic [5:0]        span;
	logic              dir_up;
	logic [7:0]        len_p7;
	logic [3:0]        swap_cnt;
	logic [63:0]       field_o;
	logic [7:0]        byte_o;

	assign in_acc   = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	assign flen       = (frame_len_q > 7'(FRAME_BYTES)) ? 7'(FRAME_BYTES) : frame_len_q;
	assign end_pos    = {1'b0, bit_offset} + {3'b000, bit_length};
	assign last_pos   = end_pos - 10'd1;
	assign bad_len    = (bit_length == 7'd0) || (bit_length > MAX_FIELD_BITS);
	assign past_end   = end_pos > {flen, 3'b000};
	assign first_byte = bit_offset[8:3];
	assign last_byte  = last_pos[8:3];
	assign span       = last_byte - first_byte;
	assign dir_up     = (cmd_in == CMD_EXTRACT) == msb_first;

	assign len_p7   = {1'b0, len_q} + 8'd7;
	assign swap_cnt = len_p7[6:3];

	assign field_o = (cmd_q == CMD_EXTRACT && status_q == STS_OK) ? work_q[63:0] : 64'd0;
	assign byte_o  = (cmd_q == CMD_READ) ? work_q[7:0] : 8'h00;

	always_comb begin
		req = '0;
		if (state_q == S_IDLE) begin
			req.rd      = in_acc && cmd_in == CMD_READ;
			req.rd_addr = byte_index;
			req.wr      = in_acc && cmd_in == CMD_LOAD;
			req.wr_addr = byte_index;
			req.wr_data = byte_value;
		end else if (state_q == S_RUN) begin
			req.rd      = rd_cnt_q != 4'd0;
			req.rd_addr = addr_q;
			req.wr      = pend_q && cmd_q == CMD_INSERT;
			req.wr_addr = prev_addr_q;
			req.wr_data = (rd_data & ~mm_q[7:0]) | (work_q[7:0] & mm_q[7:0]);
		end
	end

	fbfa_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			frame_len_q <= FRAME_LEN_RST;
			rd_cnt_q    <= 4'd0;
			pend_q      <= 1'b0;
			m_tvalid_q  <= 1'b0;
		end else begin
			pend_q <= req.rd;
			if (cfg_we) begin
				frame_len_q <= cfg_wdata;
			end
			if (state_q == S_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						priority if (cmd_in == CMD_LOAD) begin
							state_q <= S_DONE;
						end else if (cmd_in == CMD_READ) begin
							state_q <= S_RDB;
						end else if (bad_len || past_end) begin
							state_q <= S_DONE;
						end else if (cmd_in == CMD_EXTRACT) begin
							rd_cnt_q <= span[3:0] + 4'd1;
							state_q  <= S_RUN;
						end else begin
							rd_cnt_q <= span[3:0] + 4'd1;
							state_q  <= S_SWAP;
						end
					end
				end
				S_RDB: begin
					state_q <= S_DONE;
				end
				S_RUN: begin
					if (req.rd) begin
						rd_cnt_q <= rd_cnt_q - 4'd1;
					end
					if (rd_cnt_q == 4'd0 && !pend_q) begin
						state_q <= (cmd_q == CMD_EXTRACT) ? S_ALIGN : S_DONE;
					end
				end
				S_ALIGN: begin
					state_q <= S_SWAP;
				end
				S_SWAP: begin
					state_q <= (cmd_q == CMD_EXTRACT) ? S_DONE : S_SHIFT;
				end
				S_SHIFT: begin
					state_q <= S_RUN;
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					cmd_q    <= cmd_in;
					len_q    <= bit_length;
					sh_q     <= msb_first ? ~last_pos[2:0] : bit_offset[2:0];
					swap_q   <= (bit_length > 7'd8) && (msb_first ^ big_endian);
					dir_up_q <= dir_up;
					addr_q   <= dir_up ? first_byte : last_byte;
					if (cmd_in == CMD_LOAD || cmd_in == CMD_READ) begin
						status_q <= STS_OK;
					end else if (bad_len) begin
						status_q <= STS_BAD_LEN;
					end else if (past_end) begin
						status_q <= STS_PAST_END;
					end else begin
						status_q <= STS_OK;
					end
					if (cmd_in == CMD_INSERT) begin
						work_q <= {8'h00, field_value & len_mask(bit_length)};
					end else begin
						work_q <= '0;
					end
				end
			end
			S_RDB: begin
				work_q <= {64'd0, rd_data};
			end
			S_RUN: begin
				if (req.rd) begin
					addr_q      <= dir_up_q ? addr_q + 1'b1 : addr_q - 1'b1;
					prev_addr_q <= addr_q;
				end
				if (pend_q) begin
					if (cmd_q == CMD_EXTRACT) begin
						work_q <= {work_q[63:0], rd_data};
					end else begin
						work_q <= work_q >> 8;
						mm_q   <= mm_q >> 8;
					end
				end
			end
			S_ALIGN: begin
				work_q <= {8'h00, 64'(work_q >> sh_q) & len_mask(len_q)};
			end
			S_SWAP: begin
				if (swap_q) begin
					work_q <= {8'h00, swap_bytes(work_q[63:0], swap_cnt) & len_mask(len_q)};
				end
			end
			S_SHIFT: begin
				work_q <= work_q << sh_q;
				mm_q   <= {8'h00, len_mask(len_q)} << sh_q;
			end
			S_DONE: begin
				if (out_free) begin
					m_tdata_q <= {6'd0, status_q, byte_o, field_o};
				end
			end
			default: begin
			end
		endcase
	end

	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	a_store_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		req.wr |-> (state_q == S_IDLE && cmd_in == CMD_LOAD)
			|| (state_q == S_RUN && cmd_q == CMD_INSERT))
		else $error("Frame store written outside a load or an insert pass.");

	a_span_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rd_cnt_q <= 4'd9)
		else $error("Byte count exceeds the widest field span.");

	a_pend_state: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> state_q == S_RUN || state_q == S_RDB)
		else $error("Store read data returned with no consumer.");

	a_done_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_DONE && m_tvalid_q && !m_tready |=> state_q == S_DONE)
		else $error("Result left its state while the output was stalled.");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tdata_q[73:72] != STS_OK |-> m_tdata_q[71:0] == 72'd0)
		else $error("Failed transaction carries nonzero data.");

endmodule

`default_nettype wire

FILE: src/fbfa_store.sv
// ----------------------------------------------------------------------------
// Frame byte store
// One write port and one registered read port; bytes never written read zero.
// ----------------------------------------------------------------------------
`default_nettype none

module fbfa_store
	import fbfa_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire store_req_t req,
	output logic      [7:0] rd_data
);

	logic [7:0]             mem [FRAME_BYTES];
	logic [FRAME_BYTES-1:0] valid_q;
	logic [7:0]             mem_rd_q;
	logic                   vld_rd_q;

	always_ff @(posedge clk) begin
		if (req.wr) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd) begin
			mem_rd_q <= mem[req.rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			vld_rd_q <= 1'b0;
		end else begin
			if (req.wr) begin
				valid_q[req.wr_addr] <= 1'b1;
			end
			if (req.rd) begin
				vld_rd_q <= valid_q[req.rd_addr];
			end
		end
	end

	assign rd_data = vld_rd_q ? mem_rd_q : 8'h00;

endmodule

`default_nettype wire
